/* src/cfpe_pkg.sv */
// shared constants, types and coefficient helper for the cosine filter phasor estimator
package cfpe_pkg;

  localparam int DEF_SAMPLES_PER_CYCLE = 16;
  localparam int DEF_SAMPLE_WIDTH      = 16;
  localparam int REF_W                 = 16;
  localparam int COEF_W                = 18;
  localparam int FILT_FRAC             = 17;
  localparam int REF_SCALE             = 14;
  localparam int PHASOR_SCALE          = 12;
  localparam int GAIN_SHIFT            = 42;
  localparam int GAIN_SPLIT            = 15;

  localparam int CORDIC_STEPS = 30;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int ANGLE_W      = 32;
  localparam int Z_W          = ANGLE_W + 2;

  localparam longint INV_GAIN_Q30 = 652032874;
  localparam longint QUARTER_TURN = 64'sd1073741824;
  localparam longint HALF_TURN    = 64'sd2147483648;
  localparam longint FULL_TURN    = 64'sd4294967296;

  localparam logic [GAIN_SPLIT-1:0] GAIN_LO = GAIN_SPLIT'(INV_GAIN_Q30 & 32767);
  localparam logic [GAIN_SPLIT-1:0] GAIN_HI = GAIN_SPLIT'(INV_GAIN_Q30 >> GAIN_SPLIT);

  localparam logic [ANGLE_W-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
    32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
    32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
  };

  typedef struct packed {
    logic start;
    logic vectoring;
  } cordic_cmd_t;

  typedef struct packed {
    logic clear;
    logic en;
  } mac_ctl_t;

  // cordic cosine of a binary angle, used only to build the coefficient table
  function automatic longint coef_cos(longint ang);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    z = ang;
    if (z >= HALF_TURN) z = z - FULL_TURN;
    x = INV_GAIN_Q30;
    y = 0;
    if (z > QUARTER_TURN || z < -QUARTER_TURN) begin
      z = (z > 0) ? z - HALF_TURN : z + HALF_TURN;
      x = -x;
      y = -y;
    end
    for (int k = 0; k < CORDIC_STEPS; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - longint'(ATAN_TURNS[k]);
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + longint'(ATAN_TURNS[k]);
      end
    end
    return x;
  endfunction

endpackage

/* src/cfpe_in_if.sv */
// input channel: one sample plus reference phasor per transfer
interface cfpe_in_if #(
  parameter int SAMPLE_WIDTH = cfpe_pkg::DEF_SAMPLE_WIDTH
);
  import cfpe_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic signed [REF_W-1:0]  ref_real;
  logic signed [REF_W-1:0]  ref_imag;
  logic                     ref_present;

  modport source (output valid, sample, ref_real, ref_imag, ref_present, input ready);
  modport sink   (input valid, sample, ref_real, ref_imag, ref_present, output ready);
endinterface

/* src/cfpe_out_if.sv */
// output channel: one phasor per transfer
interface cfpe_out_if #(
  parameter int OUT_WIDTH = cfpe_pkg::DEF_SAMPLE_WIDTH + 2
);
  logic                        valid;
  logic                        ready;
  logic signed [OUT_WIDTH-1:0] phasor_real;
  logic signed [OUT_WIDTH-1:0] phasor_imag;

  modport source (output valid, phasor_real, phasor_imag, input ready);
  modport sink   (input valid, phasor_real, phasor_imag, output ready);
endinterface

/* src/cfpe_ram.sv */
// generic single write port ram with registered read
module cfpe_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* src/cfpe_mac.sv */
// multiply-accumulate for the cosine filter sum
module cfpe_mac #(
  parameter int SAMPLE_WIDTH = cfpe_pkg::DEF_SAMPLE_WIDTH,
  parameter int ACC_W        = 40
) (
  input  logic                            clk,
  input  cfpe_pkg::mac_ctl_t              ctl,
  input  logic signed [SAMPLE_WIDTH-1:0]  sample,
  input  logic signed [cfpe_pkg::COEF_W-1:0] coef,
  output logic signed [ACC_W-1:0]         acc
);
  import cfpe_pkg::*;

  logic signed [SAMPLE_WIDTH+COEF_W-1:0] prod;

  assign prod = sample * coef;

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc <= '0;
    end else if (ctl.en) begin
      acc <= acc + ACC_W'(prod);
    end
  end
endmodule

/* src/cfpe_cordic.sv */
// iterative cordic, one micro-rotation per cycle, rotation or vectoring mode
module cfpe_cordic #(
  parameter int DATA_W = 33
) (
  input  logic                               clk,
  input  logic                               rst,
  input  cfpe_pkg::cordic_cmd_t              cmd,
  input  logic signed [DATA_W-1:0]           x_in,
  input  logic signed [DATA_W-1:0]           y_in,
  input  logic [cfpe_pkg::ANGLE_W-1:0]       angle_in,
  output logic signed [DATA_W-1:0]           x_out,
  output logic signed [DATA_W-1:0]           y_out,
  output logic [cfpe_pkg::ANGLE_W-1:0]       angle_out,
  output logic                               done
);
  import cfpe_pkg::*;

  localparam logic signed [Z_W-1:0] Z_QUARTER = Z_W'(QUARTER_TURN);
  localparam logic signed [Z_W-1:0] Z_HALF    = Z_W'(HALF_TURN);

  logic signed [DATA_W-1:0] x;
  logic signed [DATA_W-1:0] y;
  logic signed [Z_W-1:0]    z;
  logic [STEP_W-1:0]        k;
  logic                     busy;
  logic                     vec;
  logic signed [Z_W-1:0]    z_in;
  logic signed [Z_W-1:0]    atan;
  logic signed [DATA_W-1:0] dx;
  logic signed [DATA_W-1:0] dy;
  logic                     pos;

  assign z_in = Z_W'($signed(angle_in));
  assign atan = $signed({2'b00, ATAN_TURNS[k]});
  assign dx   = y >>> k;
  assign dy   = x >>> k;
  // vectoring drives y toward zero, rotation drives z toward zero
  assign pos  = vec ? (y <= 0) : (z >= 0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      k    <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        k    <= '0;
        vec  <= cmd.vectoring;
        if (cmd.vectoring) begin
          if (x_in < 0) begin
            x <= -x_in;
            y <= -y_in;
            z <= Z_HALF;
          end else begin
            x <= x_in;
            y <= y_in;
            z <= '0;
          end
        end else begin
          // fold the angle into the right half plane
          if (z_in > Z_QUARTER || z_in < -Z_QUARTER) begin
            x <= -x_in;
            y <= -y_in;
            z <= (z_in > 0) ? z_in - Z_HALF : z_in + Z_HALF;
          end else begin
            x <= x_in;
            y <= y_in;
            z <= z_in;
          end
        end
      end else if (busy) begin
        if (pos) begin
          x <= x - dx;
          y <= y + dy;
          z <= z - atan;
        end else begin
          x <= x + dx;
          y <= y - dy;
          z <= z + atan;
        end
        if (k == STEP_W'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          k <= k + 1'b1;
        end
      end
    end
  end

  assign x_out     = x;
  assign y_out     = y;
  assign angle_out = z[ANGLE_W-1:0];
endmodule

/* src/cosine_filter_phasor_estimator_core.sv */
// top level: full-cycle cosine filter phasor estimator with reference rotation
//
//  channel  | dir | payload
//  ---------+-----+----------------------------------------------
//  request  | in  | sample, ref_real, ref_imag, ref_present
//  result   | out | phasor_real, phasor_imag
//
// without rotation one item runs the N-tap mac through one multiplier; with
// rotation it adds two 30-step passes of the shared cordic, then a split gain
// multiply. request is ready only while the sequencer is idle.
// the result register lets the next item start while a result waits; a stalled
// result holds the sequencer at its last step. reset clears both rings at once
// through per-entry valid bits, no clearing pass.
module cosine_filter_phasor_estimator_core #(
  parameter int SAMPLES_PER_CYCLE = cfpe_pkg::DEF_SAMPLES_PER_CYCLE,
  parameter int SAMPLE_WIDTH      = cfpe_pkg::DEF_SAMPLE_WIDTH
) (
  input logic       clk,
  input logic       rst,
  cfpe_in_if.sink   request,
  cfpe_out_if.source result
);
  import cfpe_pkg::*;

  localparam int N      = SAMPLES_PER_CYCLE;
  localparam int IW     = $clog2(N);
  localparam int CNT_W  = $clog2(N + 1);
  localparam int OUT_W  = SAMPLE_WIDTH + 2;
  localparam int ACC_W  = SAMPLE_WIDTH + COEF_W + $clog2(N) + 1;
  localparam int DW     = ((OUT_W + PHASOR_SCALE > REF_W + REF_SCALE) ?
                           OUT_W + PHASOR_SCALE : REF_W + REF_SCALE) + 3;
  localparam int PW     = DW + 2 * GAIN_SPLIT + 2;

  localparam longint OUT_MAX = (64'sd1 <<< (OUT_W - 1)) - 1;
  localparam longint OUT_MIN = -OUT_MAX - 1;
  localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(OUT_MAX);
  localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(OUT_MIN);
  localparam logic signed [PW-1:0]    P_MAX   = PW'(OUT_MAX);
  localparam logic signed [PW-1:0]    P_MIN   = PW'(OUT_MIN);
  localparam logic signed [OUT_W-1:0] O_MAX   = OUT_W'(OUT_MAX);

  localparam logic [IW-1:0] W_RESET = IW'(N - 1);
  localparam logic [IW-1:0] Q_RESET = IW'((N / 4 + N - 1) % N);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MAC   = 4'd1;
  localparam logic [3:0] S_FILT  = 4'd2;
  localparam logic [3:0] S_QRD   = 4'd3;
  localparam logic [3:0] S_VGO   = 4'd4;
  localparam logic [3:0] S_VWAIT = 4'd5;
  localparam logic [3:0] S_RGO   = 4'd6;
  localparam logic [3:0] S_RWAIT = 4'd7;
  localparam logic [3:0] S_MUL   = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  // coefficient table, built at elaboration
  logic signed [COEF_W-1:0] coef_table [N];
  for (genvar gi = 0; gi < N; gi++) begin : g_coef
    localparam longint ANG = (longint'(gi) <<< 32) / SAMPLES_PER_CYCLE;
    localparam longint CX  = coef_cos(ANG);
    localparam longint NUM = 2 * CX;
    localparam longint DEN = SAMPLES_PER_CYCLE * 8192;
    localparam longint MAG = (NUM < 0) ? -NUM : NUM;
    localparam longint QM  = (MAG + DEN / 2) / DEN;
    localparam longint CQ  = (NUM < 0) ? -QM : QM;
    assign coef_table[gi] = COEF_W'(CQ);
  end

  logic [3:0]               state;
  logic [IW-1:0]            w_idx;
  logic [IW-1:0]            q_idx;
  logic [IW-1:0]            cur_w;
  logic [IW-1:0]            cur_q;
  logic [IW-1:0]            rd_addr;
  logic [CNT_W-1:0]         cnt;
  logic                     pend;
  logic [IW-1:0]            coef_sel;
  logic                     sval_d;
  logic                     fval_d;
  logic [N-1:0]             svalid;
  logic [N-1:0]             fvalid;
  logic signed [REF_W-1:0]  rr_q;
  logic signed [REF_W-1:0]  ri_q;
  logic                     rp_q;
  logic signed [OUT_W-1:0]  re_q;
  logic signed [OUT_W-1:0]  im_q;
  logic [ANGLE_W-1:0]       ra;
  logic signed [DW-1:0]     rot_x;
  logic signed [DW-1:0]     rot_y;
  logic signed [PW-1:0]     macc;
  logic [2:0]               mcnt;
  logic                     out_valid;
  logic signed [OUT_W-1:0]  out_re;
  logic signed [OUT_W-1:0]  out_im;

  logic                     accept;
  logic [SAMPLE_WIDTH-1:0]  s_rdata;
  logic [OUT_W-1:0]         f_rdata;
  logic signed [OUT_W-1:0]  filt_sat;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_sh;
  logic signed [OUT_W:0]    neg_q;
  logic signed [OUT_W-1:0]  im_sat;
  mac_ctl_t                 mac_ctl;
  logic signed [SAMPLE_WIDTH-1:0] mac_sample;
  cordic_cmd_t              cmd;
  logic signed [DW-1:0]     c_x_in;
  logic signed [DW-1:0]     c_y_in;
  logic [ANGLE_W-1:0]       c_angle_in;
  logic signed [DW-1:0]     c_x_out;
  logic signed [DW-1:0]     c_y_out;
  logic [ANGLE_W-1:0]       c_angle_out;
  logic                     c_done;
  logic signed [DW-1:0]     mul_a;
  logic [GAIN_SPLIT-1:0]    mul_b;
  logic signed [DW+GAIN_SPLIT:0] prod;
  logic signed [PW-1:0]     prod_ext;
  logic signed [PW-1:0]     gain_sh;
  logic signed [OUT_W-1:0]  gain_sat;
  logic                     rotate_req;
  logic                     out_load;

  assign accept        = request.valid && request.ready;
  assign request.ready = (state == S_IDLE);

  cfpe_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(N)) u_sample_ring (
    .clk   (clk),
    .we    (accept),
    .waddr (w_idx),
    .wdata (request.sample),
    .raddr (rd_addr),
    .rdata (s_rdata)
  );

  cfpe_ram #(.WIDTH(OUT_W), .DEPTH(N)) u_filtered_ring (
    .clk   (clk),
    .we    (state == S_FILT),
    .waddr (cur_w),
    .wdata (filt_sat),
    .raddr (cur_q),
    .rdata (f_rdata)
  );

  // entries never written since reset read as zero
  assign mac_sample    = sval_d ? $signed(s_rdata) : '0;
  assign mac_ctl.clear = accept;
  assign mac_ctl.en    = (state == S_MAC) && pend;

  cfpe_mac #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .ACC_W(ACC_W)) u_mac (
    .clk    (clk),
    .ctl    (mac_ctl),
    .sample (mac_sample),
    .coef   (coef_table[coef_sel]),
    .acc    (acc)
  );

  // round half up, then saturate
  assign acc_sh = (acc + (ACC_W'(1) <<< (FILT_FRAC - 1))) >>> FILT_FRAC;
  always_comb begin
    if (acc_sh > ACC_MAX) filt_sat = OUT_W'(ACC_MAX);
    else if (acc_sh < ACC_MIN) filt_sat = OUT_W'(ACC_MIN);
    else filt_sat = acc_sh[OUT_W-1:0];
  end

  assign neg_q  = -((OUT_W + 1)'(fval_d ? $signed(f_rdata) : $signed(OUT_W'(0))));
  assign im_sat = (neg_q > (OUT_W + 1)'(O_MAX)) ? O_MAX : neg_q[OUT_W-1:0];

  assign rotate_req = rp_q && (rr_q != 0 || ri_q != 0);

  assign cmd.start     = (state == S_VGO) || (state == S_RGO);
  assign cmd.vectoring = (state == S_VGO);
  always_comb begin
    if (state == S_VGO) begin
      c_x_in = DW'(rr_q) <<< REF_SCALE;
      c_y_in = DW'(ri_q) <<< REF_SCALE;
    end else begin
      c_x_in = DW'(re_q) <<< PHASOR_SCALE;
      c_y_in = DW'(im_q) <<< PHASOR_SCALE;
    end
  end
  // rotate by minus the reference angle
  assign c_angle_in = (~ra) + 1'b1;

  cfpe_cordic #(.DATA_W(DW)) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .x_in      (c_x_in),
    .y_in      (c_y_in),
    .angle_in  (c_angle_in),
    .x_out     (c_x_out),
    .y_out     (c_y_out),
    .angle_out (c_angle_out),
    .done      (c_done)
  );

  // gain correction split in two partial products per part
  assign mul_a    = (mcnt < 3'd2) ? rot_x : rot_y;
  assign mul_b    = (mcnt == 3'd0 || mcnt == 3'd2) ? GAIN_LO : GAIN_HI;
  assign prod     = mul_a * $signed({1'b0, mul_b});
  assign prod_ext = PW'(prod);
  assign gain_sh  = (macc + (PW'(1) <<< (GAIN_SHIFT - 1))) >>> GAIN_SHIFT;
  always_comb begin
    if (gain_sh > P_MAX) gain_sat = OUT_W'(P_MAX);
    else if (gain_sh < P_MIN) gain_sat = OUT_W'(P_MIN);
    else gain_sat = gain_sh[OUT_W-1:0];
  end

  assign out_load = (state == S_DONE) && (!out_valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      w_idx     <= W_RESET;
      q_idx     <= Q_RESET;
      svalid    <= '0;
      fvalid    <= '0;
      pend      <= 1'b0;
      cnt       <= '0;
      mcnt      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (result.ready) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            svalid[w_idx] <= 1'b1;
            cur_w   <= w_idx;
            cur_q   <= q_idx;
            rd_addr <= w_idx;
            w_idx   <= (w_idx == '0) ? W_RESET : w_idx - 1'b1;
            q_idx   <= (q_idx == '0) ? W_RESET : q_idx - 1'b1;
            cnt     <= '0;
            pend    <= 1'b0;
            rr_q    <= request.ref_real;
            ri_q    <= request.ref_imag;
            rp_q    <= request.ref_present;
            state   <= S_MAC;
          end
        end
        S_MAC: begin
          // one read issued per cycle, each accumulated in the cycle after
          pend     <= (cnt != CNT_W'(N));
          coef_sel <= cnt[IW-1:0];
          sval_d   <= svalid[rd_addr];
          if (cnt != CNT_W'(N)) begin
            cnt     <= cnt + 1'b1;
            rd_addr <= (rd_addr == W_RESET) ? '0 : rd_addr + 1'b1;
          end else if (!pend) begin
            state <= S_FILT;
          end
        end
        S_FILT: begin
          fvalid[cur_w] <= 1'b1;
          fval_d <= fvalid[cur_q];
          re_q   <= filt_sat;
          state  <= S_QRD;
        end
        S_QRD: begin
          im_q  <= im_sat;
          state <= rotate_req ? S_VGO : S_DONE;
        end
        S_VGO: begin
          state <= S_VWAIT;
        end
        S_VWAIT: begin
          if (c_done) begin
            ra    <= c_angle_out;
            state <= S_RGO;
          end
        end
        S_RGO: begin
          state <= S_RWAIT;
        end
        S_RWAIT: begin
          if (c_done) begin
            rot_x <= c_x_out;
            rot_y <= c_y_out;
            mcnt  <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          mcnt <= mcnt + 1'b1;
          unique case (mcnt)
            3'd0: macc <= prod_ext;
            3'd1: macc <= macc + (prod_ext <<< GAIN_SPLIT);
            3'd2: begin
              re_q <= gain_sat;
              macc <= prod_ext;
            end
            3'd3: macc <= macc + (prod_ext <<< GAIN_SPLIT);
            default: begin
              im_q  <= gain_sat;
              state <= S_DONE;
            end
          endcase
        end
        S_DONE: begin
          if (out_load) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_re <= re_q;
      out_im <= im_q;
    end
  end

  assign result.valid       = out_valid;
  assign result.phasor_real = out_re;
  assign result.phasor_imag = out_im;
endmodule
